@@ hdl/cls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_pkg: shared types and constants of the combined LCG shuffle generator
// Generator constants, reciprocals for the constant divisions, unit command
// and response structs.
// ----------------------------------------------------------------------------
package cls_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int WARM_W      = $clog2(TABLE_DEPTH + 8);
  localparam int WARM_STEPS  = TABLE_DEPTH + 8;
  localparam logic [WARM_W-1:0] WARM_LAST  = WARM_W'(WARM_STEPS - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(TABLE_DEPTH - 1);
  localparam logic [30:0]       SLOT_LIMIT = 31'(TABLE_DEPTH);

  localparam logic [30:0] MOD1       = 31'd2147483563;
  localparam logic [30:0] MOD2       = 31'd2147483399;
  localparam logic [30:0] MOD1_LESS1 = 31'd2147483562;
  localparam logic [30:0] CLAMP_FROM = 31'd2147483306;

  localparam logic [15:0] MUL1 = 16'd40014;
  localparam logic [15:0] MUL2 = 16'd40692;
  localparam logic [15:0] QUO1 = 16'd53668;
  localparam logic [15:0] QUO2 = 16'd52774;
  localparam logic [13:0] REM1 = 14'd12211;
  localparam logic [13:0] REM2 = 14'd3791;

  localparam longint unsigned TWO32      = 64'd4294967296;
  localparam longint unsigned SLOT_DIV_L = 64'd1 + (64'd2147483562 / TABLE_DEPTH);
  localparam logic [30:0]     SLOT_DIV   = 31'(SLOT_DIV_L);

  // floor(2^32 / divisor): quotient estimate is low by at most one
  localparam logic [16:0] RECIP1     = 17'(TWO32 / 64'd53668);
  localparam logic [16:0] RECIP2     = 17'(TWO32 / 64'd52774);
  localparam logic [16:0] RECIP_SLOT = 17'(TWO32 / SLOT_DIV_L);

  typedef enum logic [1:0] {
    MODE_GEN1 = 2'd0,
    MODE_GEN2 = 2'd1,
    MODE_SLOT = 2'd2
  } cls_mode_t;

  typedef struct packed {
    logic [16:0] recip;
    logic [30:0] divisor;
    logic [15:0] mul;
    logic [13:0] remc;
    logic [30:0] modulus;
  } cls_consts_t;

  typedef struct packed {
    logic        start;
    cls_mode_t   mode;
    logic [30:0] operand;
  } cls_cmd_t;

  typedef struct packed {
    logic        done;
    logic [30:0] value;
  } cls_rsp_t;

  function automatic cls_consts_t mode_consts(input cls_mode_t m);
    cls_consts_t c;
    unique case (m)
      MODE_GEN1: c = '{recip: RECIP1, divisor: 31'(QUO1), mul: MUL1, remc: REM1,
                       modulus: MOD1};
      MODE_GEN2: c = '{recip: RECIP2, divisor: 31'(QUO2), mul: MUL2, remc: REM2,
                       modulus: MOD2};
      default:   c = '{recip: RECIP_SLOT, divisor: SLOT_DIV, mul: 16'd0, remc: 14'd0,
                       modulus: 31'd0};
    endcase
    return c;
  endfunction

endpackage

@@ hdl/cls_schrage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_schrage: shared multi-cycle congruential step and constant divider
// One multiplier, reused across the multiply phases. Generator modes return
// a*(s mod q) - (s div q)*r, wrapped into range; slot mode returns s div D.
// ----------------------------------------------------------------------------
module cls_schrage import cls_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cls_cmd_t cmd,
  output cls_rsp_t rsp
);

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_RECIP = 7'b0000010,
    PH_BACK  = 7'b0000100,
    PH_FIX   = 7'b0001000,
    PH_AREM  = 7'b0010000,
    PH_KR    = 7'b0100000,
    PH_SUB   = 7'b1000000
  } phase_t;

  phase_t      phase;
  cls_mode_t   mode;
  cls_consts_t cst;
  logic [30:0] s_reg;
  logic [61:0] prod;
  logic [15:0] k;
  logic [30:0] rem;
  logic [31:0] acc;
  logic        done;
  logic [30:0] value;

  logic [30:0] mul_a;
  logic [30:0] mul_b;
  logic [15:0] k0;
  logic [30:0] rem_raw;
  logic [31:0] rem_less;
  logic        fix_up;
  logic [15:0] k_fixed;
  logic [32:0] diff;
  logic [32:0] wrapped;

  assign cst = mode_consts(mode);
  assign k0  = prod[47:32];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (phase)
      PH_RECIP: begin
        mul_a = s_reg;
        mul_b = 31'(cst.recip);
      end
      PH_BACK: begin
        mul_a = 31'(k0);
        mul_b = cst.divisor;
      end
      PH_AREM: begin
        mul_a = rem;
        mul_b = 31'(cst.mul);
      end
      PH_KR: begin
        mul_a = 31'(k);
        mul_b = 31'(cst.remc);
      end
      default: ;
    endcase
  end

  // estimate is never high, so one correction step is enough
  assign rem_raw  = s_reg - prod[30:0];
  assign rem_less = {1'b0, rem_raw} - {1'b0, cst.divisor};
  assign fix_up   = !rem_less[31];
  assign k_fixed  = fix_up ? k + 16'd1 : k;

  assign diff    = {1'b0, acc} - {1'b0, prod[31:0]};
  assign wrapped = diff + {2'b0, cst.modulus};

  always_ff @(posedge clk) begin
    prod <= {31'b0, mul_a} * {31'b0, mul_b};
    unique case (phase)
      PH_IDLE:  begin
        s_reg <= cmd.operand;
        mode  <= cmd.mode;
      end
      PH_BACK:  k <= k0;
      PH_FIX:   begin
        k     <= k_fixed;
        rem   <= fix_up ? rem_less[30:0] : rem_raw;
        value <= {15'b0, k_fixed};
      end
      PH_KR:    acc <= prod[31:0];
      PH_SUB:   value <= diff[32] ? wrapped[30:0] : diff[30:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      // pulse done as the last phase of the mode finishes
      done <= (phase == PH_SUB) || (phase == PH_FIX && mode == MODE_SLOT);
      unique case (phase)
        PH_IDLE:  if (cmd.start) phase <= PH_RECIP;
        PH_RECIP: phase <= PH_BACK;
        PH_BACK:  phase <= PH_FIX;
        PH_FIX:   phase <= (mode == MODE_SLOT) ? PH_IDLE : PH_AREM;
        PH_AREM:  phase <= PH_KR;
        PH_KR:    phase <= PH_SUB;
        PH_SUB:   phase <= PH_IDLE;
        default:  phase <= PH_IDLE;
      endcase
    end
  end

  assign rsp = '{done: done, value: value};

endmodule

@@ hdl/combined_lcg_shuffle_rng.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng: combined two-LCG uniform generator with shuffle
// Each draw steps both generators, picks a table slot from the last output
// and mixes. Seeding runs the warm-up steps and fills the table first.
// ----------------------------------------------------------------------------
// Draws: one at a time, draw_stall stays high until the result is sent;
//   a draw that seeds adds 40 generator steps of warm-up.
// All generator steps and the slot division run in the shared step unit.
// Reset: state clears, the next draw seeds from seed_magnitude (reset 1);
//   the shuffle table has no reset and is filled by seeding.
module combined_lcg_shuffle_rng import cls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [30:0] cfg_write_data,
  input  logic        draw_valid,
  output logic        draw_stall,
  input  logic        restart,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [30:0] deviate_numerator,
  output logic        clamped_high
);

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b000000000001,
    ST_WARM_GO   = 12'b000000000010,
    ST_WARM_WAIT = 12'b000000000100,
    ST_G1_GO     = 12'b000000001000,
    ST_G1_WAIT   = 12'b000000010000,
    ST_G2_GO     = 12'b000000100000,
    ST_G2_WAIT   = 12'b000001000000,
    ST_SLOT_GO   = 12'b000010000000,
    ST_SLOT_WAIT = 12'b000100000000,
    ST_READ      = 12'b001000000000,
    ST_MIX       = 12'b010000000000,
    ST_SEND      = 12'b100000000000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [30:0] seed_magnitude;
  logic        needs_seeding;
  logic [30:0] first_lcg;
  logic [30:0] second_lcg;
  logic [30:0] last_shuffled;
  logic [WARM_W-1:0] warm_i;
  logic [SLOT_W-1:0] slot;
  logic [30:0] table_rd;
  logic [30:0] shuffle_table [TABLE_DEPTH];

  cls_cmd_t    cmd;
  cls_rsp_t    rsp;
  logic        accept;
  logic        seed_now;
  logic [30:0] seed_value;
  logic        out_free;
  logic        tbl_we;
  logic [SLOT_W-1:0] tbl_waddr;
  logic [30:0] tbl_wdata;
  logic [31:0] diff;
  logic [30:0] mixed;

  cls_schrage u_cls_schrage (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  assign draw_stall = (state != ST_IDLE);
  assign accept     = draw_valid && !draw_stall;
  assign seed_now   = restart || needs_seeding || (first_lcg == 31'd0);
  // a stuck-at-zero first generator reseeds from one
  assign seed_value = (restart || needs_seeding) && (seed_magnitude != 31'd0)
                      ? seed_magnitude : 31'd1;
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    cmd.start   = 1'b0;
    cmd.mode    = MODE_GEN1;
    cmd.operand = first_lcg;
    unique case (state) inside
      ST_WARM_GO, ST_G1_GO: cmd.start = 1'b1;
      ST_G2_GO: begin
        cmd.start   = 1'b1;
        cmd.mode    = MODE_GEN2;
        cmd.operand = second_lcg;
      end
      ST_SLOT_GO: begin
        cmd.start   = 1'b1;
        cmd.mode    = MODE_SLOT;
        cmd.operand = last_shuffled;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (accept) state_next = seed_now ? ST_WARM_GO : ST_G1_GO;
      ST_WARM_GO:   state_next = ST_WARM_WAIT;
      ST_WARM_WAIT: if (rsp.done) state_next = (warm_i == '0) ? ST_G1_GO : ST_WARM_GO;
      ST_G1_GO:     state_next = ST_G1_WAIT;
      ST_G1_WAIT:   if (rsp.done) state_next = ST_G2_GO;
      ST_G2_GO:     state_next = ST_G2_WAIT;
      ST_G2_WAIT:   if (rsp.done) state_next = ST_SLOT_GO;
      ST_SLOT_GO:   state_next = ST_SLOT_WAIT;
      ST_SLOT_WAIT: if (rsp.done) state_next = ST_READ;
      ST_READ:      state_next = ST_MIX;
      ST_MIX:       state_next = ST_SEND;
      ST_SEND:      if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // table write: fill during warm-up, refill the used slot on each draw
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = slot;
    tbl_wdata = first_lcg;
    if (state == ST_WARM_WAIT && rsp.done && warm_i < WARM_W'(TABLE_DEPTH)) begin
      tbl_we    = 1'b1;
      tbl_waddr = warm_i[SLOT_W-1:0];
      tbl_wdata = rsp.value;
    end else if (state == ST_MIX) begin
      tbl_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) shuffle_table[tbl_waddr] <= tbl_wdata;
    if (state == ST_READ) table_rd <= shuffle_table[slot];
  end

  assign diff  = {1'b0, table_rd} - {1'b0, second_lcg};
  assign mixed = (diff[31] || diff == 32'd0) ? diff[30:0] + MOD1_LESS1 : diff[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      seed_magnitude <= 31'd1;
      needs_seeding  <= 1'b1;
      first_lcg      <= '0;
      second_lcg     <= '0;
      last_shuffled  <= '0;
      result_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) seed_magnitude <= cfg_write_data;
      if (result_valid && !result_stall && state != ST_SEND) result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept && seed_now) begin
            first_lcg  <= seed_value;
            second_lcg <= seed_value;
            warm_i     <= WARM_LAST;
          end
        end
        ST_WARM_WAIT: begin
          if (rsp.done) begin
            first_lcg <= rsp.value;
            if (warm_i == '0) begin
              last_shuffled <= rsp.value;
              needs_seeding <= 1'b0;
            end else begin
              warm_i <= warm_i - WARM_W'(1);
            end
          end
        end
        ST_G1_WAIT: if (rsp.done) first_lcg <= rsp.value;
        ST_G2_WAIT: if (rsp.done) second_lcg <= rsp.value;
        ST_SLOT_WAIT: begin
          if (rsp.done) begin
            slot <= (rsp.value >= SLOT_LIMIT) ? SLOT_LAST : rsp.value[SLOT_W-1:0];
          end
        end
        ST_MIX: last_shuffled <= mixed;
        ST_SEND: begin
          if (out_free) begin
            result_valid      <= 1'b1;
            deviate_numerator <= last_shuffled;
            clamped_high      <= (last_shuffled >= CLAMP_FROM);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/cls_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_checker: port-level checks for the combined LCG shuffle generator
// Watches the draw and result channels of the top level over time.
// ----------------------------------------------------------------------------
module cls_checker import cls_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        draw_valid,
  input logic        draw_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [30:0] deviate_numerator,
  input logic        clamped_high
);

  // hold a stalled item
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(deviate_numerator)
                                     && $stable(clamped_high))
    else $error("stalled result item changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_clamp_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> clamped_high == (deviate_numerator >= CLAMP_FROM))
    else $error("clamp flag disagrees with numerator");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> deviate_numerator != 31'd0 && deviate_numerator <= MOD1_LESS1)
    else $error("numerator out of range");

  // one draw at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    draw_valid && !draw_stall |=> draw_stall)
    else $error("draw accepted while previous draw in flight");

endmodule

bind combined_lcg_shuffle_rng cls_checker u_cls_checker (.*);
